>>> design/spsc_pkg.sv
// Shared types and constants for the nearest-neighbor sprite scaler.
// Used by spsc_front, spsc_fifo, spsc_back and sprite_scaler_nearest.
package spsc_pkg;

  // Screen geometry
  localparam int ScreenW = 320;
  localparam int ScreenH = 200;

  // Configuration register indexes
  localparam logic [1:0] CfgCenterX = 2'd0;
  localparam logic [1:0] CfgCenterY = 2'd1;
  localparam logic [1:0] CfgScale   = 2'd2;

  // Item opcodes
  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Queue between front and back
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  // Widths: size = scale >> 13 fits 18 bits, inverse of a scale >= 2^13 fits 20 bits
  localparam int OffW = 18;
  localparam int InvW = 20;
  localparam int ProdW = OffW + InvW;

  typedef struct packed {
    logic            op;
    logic [5:0]      texel_index;
    logic [7:0]      texel_value;
    logic            cov;
    logic [OffW-1:0] dx;
    logic [OffW-1:0] dy;
    logic [15:0]     pixel_addr;
  } spsc_entry_t;

endpackage

>>> design/spsc_front.sv
// Front part: configuration registers, reciprocal unit and per-pixel coverage test.
// Depends on spsc_pkg; pushes classified words into spsc_fifo.
module spsc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [30:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic [5:0]               texel_index_i,
  input  logic [7:0]               texel_value_i,
  input  logic [8:0]               pixel_x_i,
  input  logic [7:0]               pixel_y_i,
  input  logic                     full_i,
  output logic                     push_o,
  output spsc_pkg::spsc_entry_t    entry_o,
  output logic [spsc_pkg::InvW-1:0] inv_o
);
  import spsc_pkg::*;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'b01,
    DIV_RUN  = 2'b10
  } div_state_e;

  div_state_e         div_st_q, div_st_d;
  logic signed [15:0] cx_q, cy_q;
  logic [30:0]        scale_q;
  logic [31:0]        rem_q, rem_d;
  logic [InvW-1:0]    inv_q, inv_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [32:0]        rem_sh;

  logic [OffW-1:0]    size, half;
  logic signed [19:0] start_x, end_x, start_y, end_y, px_s, py_s, dx_w, dy_w;
  logic               hit_x, hit_y;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      scale_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCenterX: cx_q    <= cfg_data_i[15:0];
        CfgCenterY: cy_q    <= cfg_data_i[15:0];
        CfgScale:   scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Reciprocal 2^32 / scale, one quotient bit per cycle
  assign rem_sh = {rem_q, 1'b0};

  always_comb begin
    div_st_d = div_st_q;
    rem_d    = rem_q;
    inv_d    = inv_q;
    cnt_d    = cnt_q;
    unique case (div_st_q)
      DIV_IDLE: begin
      end
      DIV_RUN: begin
        if (rem_sh >= {2'b0, scale_q}) begin
          rem_d = 32'(rem_sh - {2'b0, scale_q});
          inv_d = {inv_q[InvW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[31:0];
          inv_d = {inv_q[InvW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          div_st_d = DIV_IDLE;
        end
      end
      default: div_st_d = DIV_IDLE;
    endcase
    // restart on every scale write
    if (cfg_we_i && cfg_idx_i == CfgScale) begin
      div_st_d = DIV_RUN;
      rem_d    = 32'd1 << (32 - InvW);
      inv_d    = '0;
      cnt_d    = 5'(InvW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_st_q <= DIV_IDLE;
      cnt_q    <= '0;
      inv_q    <= '0;
    end else begin
      div_st_q <= div_st_d;
      cnt_q    <= cnt_d;
      inv_q    <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  // Coverage test and offsets on both axes
  assign size    = scale_q[30:13];
  assign half    = size >> 1;
  assign px_s    = signed'({11'b0, pixel_x_i});
  assign py_s    = signed'({12'b0, pixel_y_i});
  assign start_x = 20'(cx_q) - signed'({2'b0, half});
  assign end_x   = start_x + signed'({2'b0, size});
  assign start_y = 20'(cy_q) - signed'({2'b0, half});
  assign end_y   = start_y + signed'({2'b0, size});
  assign dx_w    = px_s - start_x;
  assign dy_w    = py_s - start_y;
  assign hit_x   = (px_s >= start_x) && (px_s < end_x) && (32'(pixel_x_i) < ScreenW);
  assign hit_y   = (py_s >= start_y) && (py_s < end_y) && (32'(pixel_y_i) < ScreenH);

  // Build queue word
  always_comb begin
    entry_o.op          = op_i;
    entry_o.texel_index = texel_index_i;
    entry_o.texel_value = texel_value_i;
    entry_o.cov         = (|size) && hit_x && hit_y;
    entry_o.dx          = dx_w[OffW-1:0];
    entry_o.dy          = dy_w[OffW-1:0];
    entry_o.pixel_addr  = 16'(32'(pixel_y_i) * ScreenW + 32'(pixel_x_i));
  end

  assign in_ready_o = !full_i && (div_st_q == DIV_IDLE);
  assign push_o     = in_valid_i && in_ready_o;
  assign inv_o      = inv_q;

endmodule

>>> design/spsc_fifo.sv
// Short queue of classified words between front and back.
// Depends on spsc_pkg for the word type and depth.
module spsc_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  spsc_pkg::spsc_entry_t data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output spsc_pkg::spsc_entry_t data_o
);
  import spsc_pkg::*;

  spsc_entry_t       mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, rd_q;
  logic [FifoAw:0]   cnt_q;

  assign full_o  = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // Store pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FifoAw+1)'(push_i) - (FifoAw+1)'(pop_i);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FifoAw+1)'(FifoDepth)) else $error("queue count out of range");
`endif

endmodule

>>> design/spsc_back.sv
// Back part: source coordinate multiply, texel store and output register.
// Depends on spsc_pkg; pops words from spsc_fifo.
module spsc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  spsc_pkg::spsc_entry_t     entry_i,
  output logic                      pop_o,
  input  logic [spsc_pkg::InvW-1:0] inv_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      covered_o,
  output logic [7:0]                color_o,
  output logic [15:0]               pixel_addr_o
);
  import spsc_pkg::*;

  function automatic logic [2:0] src_coord(input logic [ProdW-1:0] prod);
    logic [ProdW:0] sum;
    sum = {1'b0, prod} + (ProdW+1)'(32768);
    return (sum[ProdW:16] > (ProdW-15)'(7)) ? 3'd7 : sum[18:16];
  endfunction

  logic             advance;
  logic             s1_valid_q, s1_op_q, s1_cov_q;
  logic [5:0]       s1_idx_q;
  logic [7:0]       s1_val_q;
  logic [ProdW-1:0] s1_px_q, s1_py_q;
  logic [15:0]      s1_addr_q;
  logic             s2_valid_q, s2_cov_q;
  logic [15:0]      s2_addr_q;
  logic [7:0]       rd_q;
  logic [7:0]       store_q [64];
  logic [5:0]       rd_addr;

  assign advance = !s2_valid_q || out_ready_i;
  assign pop_o   = advance && !empty_i;

  // Stage 1 valid and stage 2 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= !empty_i;
      s2_valid_q <= s1_valid_q && (s1_op_q == OpQuery);
    end
  end

  // Multiply offsets by the inverse scale
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_op_q   <= entry_i.op;
      s1_cov_q  <= entry_i.cov;
      s1_idx_q  <= entry_i.texel_index;
      s1_val_q  <= entry_i.texel_value;
      s1_addr_q <= entry_i.pixel_addr;
      s1_px_q   <= ProdW'(entry_i.dx) * ProdW'(inv_i);
      s1_py_q   <= ProdW'(entry_i.dy) * ProdW'(inv_i);
    end
  end

  assign rd_addr = {src_coord(s1_py_q), src_coord(s1_px_q)};

  // Load texels, read the sampled one
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      if (s1_op_q == OpLoad) begin
        store_q[s1_idx_q] <= s1_val_q;
      end else begin
        rd_q <= store_q[rd_addr];
      end
    end
  end

  // Hold result fields
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_cov_q  <= s1_cov_q;
      s2_addr_q <= s1_addr_q;
    end
  end

  assign out_valid_o  = s2_valid_q;
  assign covered_o    = s2_cov_q;
  assign color_o      = s2_cov_q ? rd_q : 8'd0;
  assign pixel_addr_o = s2_addr_q;

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_addr_o))
    else $error("result dropped while stalled");
  a_no_pop_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !pop_o) else $error("pop during stall");
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_valid_q && s1_op_q == OpLoad |=> !s2_valid_q)
    else $error("load produced a result");
`endif

endmodule

>>> design/sprite_scaler_nearest.sv
// Top level of the nearest-neighbor sprite scaler.
// Depends on spsc_pkg, spsc_front, spsc_fifo and spsc_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one word per cycle if ready:
//   op 0 loads texel_value_i at texel_index_i into the 8x8 sprite store and
//   gives no result; op 1 queries screen pixel (pixel_x_i, pixel_y_i).
//   Output channel (out_valid_o/out_ready_i) gives one word per query:
//   covered_o, color_o (0 when not covered) and pixel_addr_o = y*320+x.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 center_x, 1 center_y, 2 scale, 15.16).
// A query accepted into the queue passes stage 1 (offset multiply) and stage 2
// (texel read, result register) to the output. The fully pipelined back part
// takes one word per cycle while the output is not stalled. A scale write starts
// the reciprocal iteration (one quotient bit per cycle); in_ready_o stays low until it ends.
// Reset clears the config registers to zero (nothing covered) and empties
// the pipeline; the texel store holds garbage until loaded.
// When the receiver stalls, the result is held, the back pipeline freezes,
// and the 4-word queue absorbs input before in_ready_o drops.
module sprite_scaler_nearest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [5:0]  texel_index_i,
  input  logic [7:0]  texel_value_i,
  input  logic [8:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        covered_o,
  output logic [7:0]  color_o,
  output logic [15:0] pixel_addr_o
);
  import spsc_pkg::*;

  spsc_entry_t     push_word, pop_word;
  logic            push, pop, full, empty;
  logic [InvW-1:0] inv;

  // Classify and push
  spsc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .op_i, .texel_index_i, .texel_value_i,
    .pixel_x_i, .pixel_y_i,
    .full_i (full), .push_o (push), .entry_o (push_word), .inv_o (inv)
  );

  // Decouple front from back
  spsc_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i (push), .data_i (push_word), .full_o (full),
    .pop_i (pop), .empty_o (empty), .data_o (pop_word)
  );

  // Sample and deliver
  spsc_back u_back (
    .clk_i, .rst_ni,
    .empty_i (empty), .entry_i (pop_word), .pop_o (pop), .inv_i (inv),
    .out_valid_o, .out_ready_i, .covered_o, .color_o, .pixel_addr_o
  );

endmodule
